>>> design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg: shared definitions for the set-associative LRU cache lookup
// Geometry constants, the layout of one set row in the tag memory, operation
// and register codes, and the LRU rank update.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Geometry (MAX_SETS must be a power of two; the set number wraps modulo it)
  localparam int MAX_SETS  = 1024;
  localparam int MAX_WAYS  = 8;
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int NWAY_W    = $clog2(MAX_WAYS + 1);
  localparam int RANK_W    = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // Field widths fixed by the interface
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 2;
  localparam int WAY_OUT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SIB_W      = 4;
  localparam int BOB_W      = 5;
  localparam int SHIFT_W    = 6;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE       = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  // Make one way most recent; age every other in-use way that was not older.
  function automatic row_t sacl_touch(row_t r, logic [WAY_W-1:0] way,
                                      logic [NWAY_W-1:0] nways);
    row_t              res;
    logic [RANK_W-1:0] old;
    res = r;
    old = r[way].rank;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if ((j < int'(nways)) && (j != int'(way)) && (r[j].rank <= old) &&
          (r[j].rank < RANK_MAX)) begin
        res[j].rank = r[j].rank + 1'b1;
      end
    end
    res[way].rank = '0;
    return res;
  endfunction

endpackage

>>> design/set_assoc_lru_cache_lookup_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top: tag-only set-associative cache, true LRU
// Looks up each access in a set row held in one synchronous memory, updates
// valid bits, tags and LRU ranks, and reports hit/miss/eviction with totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation and address. A load
//   or store gives one result; a modify gives two (load, then store), the
//   second flagged with last. Operation code 3 is accepted and dropped.
//   Output channel (out_valid/out_ready) carries one result per transaction.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   issue them only while no transaction is in flight.
// Timing:
//   Accepting an access reads its set row into a register; the compare
//   state then compares the tags, picks the way and writes the row back.
//   A modify passes through the compare state twice; the second lookup works
//   on the forwarded row instead of rereading the memory. While the set row
//   read-modify-write through the single memory runs, in_ready stays low.
// Reset:
//   Counters clear at once; then a clearing pass writes zero to all 1024 set
//   rows, one row per cycle, with in_ready low. Configuration writes are
//   taken during the pass.
// Stall:
//   A finished result sits in the output register; while the receiver holds
//   out_ready low the next lookup waits in its compare cycle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sacl_pkg::OP_W-1:0]     operation,
  input  logic [sacl_pkg::ADDR_W-1:0]   address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic                          miss,
  output logic                          eviction,
  output logic [sacl_pkg::WAY_OUT_W-1:0] way_used,
  output logic                          last,
  output logic [sacl_pkg::CNT_W-1:0]    hit_total,
  output logic [sacl_pkg::CNT_W-1:0]    miss_total,
  output logic [sacl_pkg::CNT_W-1:0]    eviction_total
);
  import sacl_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CALC  = 3'b100
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [SIB_W-1:0] set_index_bits;
  logic [BOB_W-1:0] block_offset_bits;
  logic [SIB_W-1:0] ways_in_use;

  // Per-access registers
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             pend;        // second (store) lookup of a modify pending
  logic [SET_W-1:0] clr_cnt;

  logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;

  // Tag memory
  row_t mem [MAX_SETS];
  row_t rd_row;

  // Address decode
  logic [ADDR_W-1:0]  shifted;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   in_set;
  logic [SHIFT_W-1:0] tag_shift;
  logic [TAG_W-1:0]   in_tag;

  logic [NWAY_W-1:0]  nways;
  logic               accept, produce, mem_we;
  logic [SET_W-1:0]   wr_addr;
  row_t               wr_data;

  // Lookup results
  row_t             row_c;
  logic             hit_c, evict_c, found_c;
  logic [WAY_W-1:0] way_c;
  logic [RANK_W-1:0] best_c;

  always_comb begin
    shifted   = address >> block_offset_bits;
    set_mask  = ~({SET_W{1'b1}} << set_index_bits);
    in_set    = shifted[SET_W-1:0] & set_mask;
    tag_shift = SHIFT_W'(set_index_bits) + SHIFT_W'(block_offset_bits);
    in_tag    = (tag_shift >= SHIFT_W'(ADDR_W)) ? '0 : (address >> tag_shift);
  end

  // Clamp ways in use to 1..MAX_WAYS
  always_comb begin
    if (ways_in_use == '0) begin
      nways = NWAY_W'(1);
    end else if (NWAY_W'(ways_in_use) > NWAY_W'(MAX_WAYS)) begin
      nways = NWAY_W'(MAX_WAYS);
    end else begin
      nways = NWAY_W'(ways_in_use);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign produce  = (state == ST_CALC) && (!out_valid || out_ready);

  // Tag compare, fill/victim choice and LRU update on the row just read
  always_comb begin
    row_c   = rd_row;
    hit_c   = 1'b0;
    evict_c = 1'b0;
    found_c = 1'b0;
    way_c   = '0;
    best_c  = '0;
    // Every matching way is touched in way order; the last one is reported
    for (int j = 0; j < MAX_WAYS; j++) begin
      if ((j < int'(nways)) && rd_row[j].valid && (rd_row[j].tag == tag_q)) begin
        hit_c = 1'b1;
        way_c = WAY_W'(j);
        row_c = sacl_touch(row_c, WAY_W'(j), nways);
      end
    end
    if (!hit_c) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (!found_c && (j < int'(nways)) && !rd_row[j].valid) begin
          found_c = 1'b1;
          way_c   = WAY_W'(j);
        end
      end
      if (!found_c) begin
        // Evict the oldest; ties go to the lowest way
        for (int j = 0; j < MAX_WAYS; j++) begin
          if ((j < int'(nways)) && (rd_row[j].rank > best_c)) begin
            best_c = rd_row[j].rank;
            way_c  = WAY_W'(j);
          end
        end
        evict_c = 1'b1;
      end
      row_c[way_c].valid = 1'b1;
      row_c[way_c].tag   = tag_q;
      row_c = sacl_touch(row_c, way_c, nways);
    end
  end

  // Memory write port: clearing pass or lookup write-back
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = set_q;
    wr_data = row_c;
    if (state == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (produce) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the second lookup of a modify takes the written row
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= mem[in_set];
    end else if (produce && pend) begin
      rd_row <= row_c;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(MAX_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (operation != OP_NONE)) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (produce && !pend) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_cnt           <= '0;
      pend              <= 1'b0;
      out_valid         <= 1'b0;
      hit_cnt           <= '0;
      miss_cnt          <= '0;
      evict_cnt         <= '0;
      set_index_bits    <= SIB_W'(4);
      block_offset_bits <= BOB_W'(4);
      ways_in_use       <= SIB_W'(1);
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        pend <= (operation == OP_MODIFY);
      end else if (produce) begin
        pend <= 1'b0;
      end
      if (produce) begin
        out_valid <= 1'b1;
        if (hit_c) begin
          hit_cnt <= hit_cnt + 1'b1;
        end else begin
          miss_cnt <= miss_cnt + 1'b1;
        end
        if (evict_c) begin
          evict_cnt <= evict_cnt + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SET_INDEX_BITS:    set_index_bits    <= cfg_data[SIB_W-1:0];
          REG_BLOCK_OFFSET_BITS: block_offset_bits <= cfg_data[BOB_W-1:0];
          REG_WAYS_IN_USE:       ways_in_use       <= cfg_data[SIB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload: hold the decoded access and the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= in_set;
      tag_q <= in_tag;
    end
    if (produce) begin
      hit            <= hit_c;
      miss           <= !hit_c;
      eviction       <= evict_c;
      way_used       <= WAY_OUT_W'(way_c);
      last           <= !pend;
      hit_total      <= hit_c ? hit_cnt + 1'b1 : hit_cnt;
      miss_total     <= hit_c ? miss_cnt : miss_cnt + 1'b1;
      eviction_total <= evict_c ? evict_cnt + 1'b1 : evict_cnt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hit_xor_miss : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit ^ miss))
    else $error("result is not exactly one of hit and miss");

  a_evict_on_miss : assert property (@(posedge clk) disable iff (rst)
    (out_valid && eviction) |-> miss)
    else $error("eviction reported on a hit");

  a_one_count_per_result : assert property (@(posedge clk) disable iff (rst)
    produce |=> ((hit_cnt + miss_cnt) == ($past(hit_cnt) + $past(miss_cnt) + 1'b1)))
    else $error("hit plus miss totals did not advance by one");

  a_modify_second : assert property (@(posedge clk) disable iff (rst)
    (produce && pend) |=> ((state == ST_CALC) && !pend))
    else $error("second lookup of a modify lost");

endmodule

>>> verif/set_assoc_lru_cache_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top_tb: self-checking bench for the LRU cache
// Drives load/store/modify/no-op accesses under many set, offset and way
// settings. It predicts every lookup result with its own tag store and LRU
// ranks, and checks each result field by field, in order.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_top_tb;
  import sacl_pkg::*;

  localparam int QUIET_PAD    = 8;       // cycles for a dropped no-op to drain
  localparam int LONG_HOLD    = 400;     // receiver hold-off for the fill test
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 170;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct packed {
    logic                 hit;
    logic                 miss;
    logic                 eviction;
    logic [WAY_OUT_W-1:0] way;
    logic                 last;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     evictions;
  } lookup_result_t;

  // Hold every input at a known value from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       operation = OP_LOAD;
  logic [ADDR_W-1:0]     address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic                  miss;
  logic                  eviction;
  logic [WAY_OUT_W-1:0]  way_used;
  logic                  last;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      eviction_total;

  set_assoc_lru_cache_lookup_top DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .miss           (miss),
    .eviction       (eviction),
    .way_used       (way_used),
    .last           (last),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow cache: settings, tag store, LRU ranks and running totals
  // --------------------------------------------------------------------------
  logic [SIB_W-1:0]  set_bits    = 4'd4;
  logic [BOB_W-1:0]  offset_bits = 5'd4;
  logic [3:0]        way_count   = 4'd1;

  bit                tag_valid [MAX_SETS][MAX_WAYS];
  bit [TAG_W-1:0]    tag_store [MAX_SETS][MAX_WAYS];
  bit [RANK_W-1:0]   age_rank  [MAX_SETS][MAX_WAYS];
  bit [CNT_W-1:0]    hits_so_far;
  bit [CNT_W-1:0]    misses_so_far;
  bit [CNT_W-1:0]    evictions_so_far;

  access_t           pending_accesses [$];
  lookup_result_t    expected_results [$];

  int                mismatches = 0;
  int                cycle_count = 0;
  bit                in_taken = 1'b0;     // input transaction at the last edge
  bit                hold_off_request = 1'b0;

  // Make one way most recent; age every in-use way that was not older than it.
  task automatic promote_way(int unsigned set_no, int w, int n);
    logic [RANK_W-1:0] old;
    old = age_rank[set_no][w];
    for (int j = 0; j < n; j++) begin
      if (j != w && age_rank[set_no][j] <= old && age_rank[set_no][j] < RANK_MAX) begin
        age_rank[set_no][j] = age_rank[set_no][j] + 1'b1;
      end
    end
    age_rank[set_no][w] = '0;
  endtask

  // One lookup in one set: queue the result it must give.
  task automatic probe_set(int unsigned set_no, logic [TAG_W-1:0] tag, logic last_flag);
    lookup_result_t r;
    int             n;
    int             victim;
    int             best;
    bit             found;
    n = (way_count < 1) ? 1 : (way_count > MAX_WAYS) ? MAX_WAYS : int'(way_count);
    r = '0;
    found = 1'b0;
    victim = 0;
    // every matching way is touched in way order; the last one is reported
    for (int j = 0; j < n; j++) begin
      if (tag_valid[set_no][j] && tag_store[set_no][j] == tag) begin
        r.hit = 1'b1;
        victim = j;
        promote_way(set_no, j, n);
      end
    end
    if (r.hit) begin
      hits_so_far++;
    end else begin
      misses_so_far++;
      for (int j = 0; j < n; j++) begin
        if (!found && !tag_valid[set_no][j]) begin
          victim = j;
          found = 1'b1;
        end
      end
      if (!found) begin
        // oldest way goes; ties go to the lowest way
        best = 0;
        victim = 0;
        for (int j = 0; j < n; j++) begin
          if (age_rank[set_no][j] > best) begin
            best = age_rank[set_no][j];
            victim = j;
          end
        end
        r.eviction = 1'b1;
        evictions_so_far++;
      end
      tag_valid[set_no][victim] = 1'b1;
      tag_store[set_no][victim] = tag;
      promote_way(set_no, victim, n);
    end
    r.miss      = !r.hit;
    r.way       = WAY_OUT_W'(victim);
    r.last      = last_flag;
    r.hits      = hits_so_far;
    r.misses    = misses_so_far;
    r.evictions = evictions_so_far;
    expected_results.push_back(r);
  endtask

  // Split the address into set and tag, then run one or two lookups (none for a no-op).
  task automatic cache_access(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    logic [63:0]      set_sel;
    int unsigned      set_no;
    logic [TAG_W-1:0] tag;
    int               shift_amt;
    shift_amt = int'(set_bits) + int'(offset_bits);
    set_sel = (64'(addr) >> offset_bits) & ((64'd1 << set_bits) - 64'd1);
    set_no = int'(set_sel % MAX_SETS);
    tag = (shift_amt < 32) ? addr >> shift_amt : '0;    // wide shift leaves tag 0
    case (op)
      OP_LOAD, OP_STORE: begin
        probe_set(set_no, tag, 1'b1);
      end
      OP_MODIFY: begin
        probe_set(set_no, tag, 1'b0);
        probe_set(set_no, tag, 1'b1);
      end
      default: begin
        // no-op code: accepted and dropped, nothing changes
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge; check results, predict accepted items
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lookup_result_t want;
    in_taken = !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual hit=%0b miss=%0b way=%0d",
                   $time, hit, miss, way_used);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, hit);
          check_field("miss", want.miss, miss);
          check_field("eviction", want.eviction, eviction);
          check_field("way_used", want.way, way_used);
          check_field("last", want.last, last);
          check_field("hit_total", want.hits, hit_total);
          check_field("miss_total", want.misses, miss_total);
          check_field("eviction_total", want.evictions, eviction_total);
        end
      end
      // results of this access land behind anything already queued
      if (in_taken) begin
        cache_access(operation, address);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; hold until taken
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    access_t next_access;
    if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_accesses.size() > 0) begin
        next_access = pending_accesses.pop_front();
        in_valid  <= 1'b1;
        operation <= next_access.op;
        address   <= next_access.addr;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // a third of the bursts run back to back with no gap
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern redrawn from four random modes; long hold on request
  // --------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (hold_off_request) begin
      hold_left = LONG_HOLD;
      hold_off_request = 1'b0;
    end
    if (rx_cycle % 50 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  // Drop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("set_assoc_lru_cache_lookup_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_access(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    pending_accesses.push_back('{op, addr});
  endtask

  // Wait until nothing is queued, offered or owed, then let the pipe drain.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (QUIET_PAD) @(negedge clk);
  endtask

  // Write all three registers, one per cycle; unused data bits go random.
  task automatic apply_settings(int sib, int bob, int ways);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SET_INDEX_BITS;
    cfg_data  <= {1'($urandom), 4'(sib)};
    set_bits  = 4'(sib);
    @(negedge clk);
    cfg_index   <= REG_BLOCK_OFFSET_BITS;
    cfg_data    <= 5'(bob);
    offset_bits = 5'(bob);
    @(negedge clk);
    cfg_index <= REG_WAYS_IN_USE;
    cfg_data  <= {1'($urandom), 4'(ways)};
    way_count = 4'(ways);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] recent [$];
    logic [ADDR_W-1:0] addr;
    logic [OP_W-1:0]   op;
    logic [63:0]       a;
    int                tag_base;
    int                set_base;
    int                pick;
    int                ways;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: 16 sets, 16-byte blocks, one way.
    @(posedge clk);
    queue_access(OP_LOAD,   32'h0000_0000);   // cold miss
    queue_access(OP_STORE,  32'h0000_0000);   // hit
    queue_access(OP_MODIFY, 32'hFFFF_FFFF);   // miss then hit
    queue_access(OP_NONE,   32'h1234_5678);   // dropped
    queue_access(OP_LOAD,   32'h0000_0100);   // evict in set 0
    queue_access(OP_LOAD,   32'h0000_0000);   // evict back
    queue_access(OP_STORE,  32'hFFFF_FFF0);   // hit in the top set
    queue_access(OP_MODIFY, 32'h0000_0008);   // hit twice
    wait_quiet();

    // Two ways: fill, then evict the least recent.
    apply_settings(4, 4, 2);
    @(posedge clk);
    queue_access(OP_LOAD, 32'h0000_0000);
    queue_access(OP_LOAD, 32'h0000_0100);
    queue_access(OP_LOAD, 32'h0000_0200);
    wait_quiet();

    // Shrink to one way so way 0 takes a tag that way 1 already holds.
    apply_settings(4, 4, 1);
    @(posedge clk);
    queue_access(OP_LOAD, 32'h0000_0100);
    wait_quiet();

    // Widen again: both ways match the same tag.
    apply_settings(4, 4, 2);
    @(posedge clk);
    queue_access(OP_LOAD,  32'h0000_0100);
    queue_access(OP_STORE, 32'h0000_0200);
    wait_quiet();

    // Shift beyond the address width: tag is 0; way count above the maximum.
    apply_settings(15, 31, 15);
    @(posedge clk);
    queue_access(OP_LOAD,   32'h8000_0000);
    queue_access(OP_LOAD,   32'h7FFF_FFFF);
    queue_access(OP_MODIFY, 32'hFFFF_FFFF);
    wait_quiet();

    // More set bits than sets: set number wraps; way count zero acts as one.
    apply_settings(12, 0, 0);
    @(posedge clk);
    queue_access(OP_LOAD,  32'h0000_0C05);
    queue_access(OP_LOAD,  32'h0000_0005);
    queue_access(OP_STORE, 32'h0000_1005);

    // Random phases: fixed settings (mostly extremes) first, then random settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_quiet();
      case (p)
        0: apply_settings(10, 21, 8);
        1: apply_settings(15, 31, 15);
        2: apply_settings(0, 0, 8);
        3: apply_settings(11, 0, 0);
        4: apply_settings(2, 5, 4);
        default: begin
          if ($urandom_range(0, 4) != 0) begin
            ways = $urandom_range(1, 8);
          end else begin
            ways = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
          end
          apply_settings($urandom_range(0, 15),
                         $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 31),
                         ways);
        end
      endcase
      @(posedge clk);
      tag_base = $urandom_range(0, 1) ? 0 : int'($urandom);
      set_base = int'($urandom);
      recent.delete();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_LOAD;
        else if (pick < 70) op = OP_STORE;
        else if (pick < 95) op = OP_MODIFY;
        else                op = OP_NONE;
        // mostly a few tags in a few sets, so hits and evictions are common
        pick = $urandom_range(0, 9);
        if (pick < 2 || (pick < 4 && recent.size() == 0)) begin
          addr = $urandom;
        end else if (pick < 4) begin
          addr = recent[$urandom_range(0, recent.size() - 1)];
        end else begin
          a = 64'($urandom) & ((64'd1 << offset_bits) - 64'd1);
          a |= ((64'(set_base) + 64'($urandom_range(0, 3))) &
                ((64'd1 << set_bits) - 64'd1)) << offset_bits;
          a |= (64'(tag_base) + 64'($urandom_range(0, way_count + 2)))
               << (int'(set_bits) + int'(offset_bits));
          addr = a[ADDR_W-1:0];
        end
        recent.push_back(addr);
        if (recent.size() > 16) begin
          void'(recent.pop_front());
        end
        queue_access(op, addr);
      end
      // Fill the block: stall the receiver while the sender keeps offering.
      if (p == 2) begin
        hold_off_request = 1'b1;
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("set_assoc_lru_cache_lookup_top: match");
    end else begin
      $display("set_assoc_lru_cache_lookup_top: mismatch");
    end
    $finish;
  end

endmodule
